FILE: sv/stack_machine_alu_macros.svh
// Assertion macros used by the stack machine ALU top level, stack_machine_alu.sv.
`ifndef STACK_MACHINE_ALU_MACROS_SVH
`define STACK_MACHINE_ALU_MACROS_SVH

`ifndef SYNTHESIS
`define SMALU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smalu assertion failed");
`define SMALU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smalu assertion failed");
`else
`define SMALU_ASSERT_IMPL(label, ante, cons)
`define SMALU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/smalu_pkg.sv
`default_nettype none

package smalu_pkg;

    localparam int DATA_W            = 32;
    localparam int OP_W              = 3;
    localparam int ST_W              = 3;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int ARITH_ARG_COUNT   = 2;
    localparam int S_TDATA_W         = ((OP_W + DATA_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [ST_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [ST_W-1:0] ST_ILLEGAL   = 3'd4;

    typedef struct packed {
        logic load;
        logic decode;
        logic push_commit;
        logic sec_load;
        logic div_start;
        logic alu_commit;
        logic div_commit;
        logic out_load;
    } smalu_cmd_t;

    typedef struct packed {
        logic is_push;
        logic is_div;
        logic ok;
        logic div_done;
        logic out_free;
    } smalu_sts_t;

endpackage

`default_nettype wire

FILE: sv/smalu_ram.sv
`default_nettype none

module smalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/smalu_div.sv
`default_nettype none

module smalu_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [smalu_pkg::DATA_W-1:0] dividend,
    input  wire logic [smalu_pkg::DATA_W-1:0] divisor,
    output logic                              done,
    output logic      [smalu_pkg::DATA_W-1:0] quotient
);

    import smalu_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [DATA_W-1:0] rem_reg,   rem_next;
    logic [DATA_W-1:0] quo_reg,   quo_next;
    logic [DATA_W-1:0] den_reg,   den_next;
    logic              neg_reg,   neg_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    // restoring division on magnitudes, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

FILE: sv/smalu_ctrl.sv
`default_nettype none

module smalu_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire smalu_pkg::smalu_sts_t  sts,
    output smalu_pkg::smalu_cmd_t       cmd
);

    import smalu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EXE  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.decode = 1'b1;
                if (!sts.ok)
                begin
                    state_next = S_FIN;
                end
                else if (sts.is_push)
                begin
                    cmd.push_commit = 1'b1;
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.sec_load = 1'b1;
                if (sts.is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_EXE;
                end
            end
            S_EXE:
            begin
                cmd.alu_commit = 1'b1;
                state_next     = S_FIN;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_commit = 1'b1;
                    state_next     = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/smalu_dp.sv
`default_nettype none

module smalu_dp #(
    parameter int  STACK_DEPTH = smalu_pkg::STACK_DEPTH_DEF,
    localparam int SP_W        = $clog2(STACK_DEPTH + 1),
    localparam int AW          = $clog2(STACK_DEPTH)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [smalu_pkg::OP_W-1:0]   in_op,
    input  wire logic [smalu_pkg::DATA_W-1:0] in_push_value,
    input  wire smalu_pkg::smalu_cmd_t        cmd,
    output smalu_pkg::smalu_sts_t             sts,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic      [smalu_pkg::ST_W-1:0]   out_status,
    output logic      [smalu_pkg::DATA_W-1:0] out_top_value,
    output logic      [SP_W-1:0]              out_stack_depth
);

    import smalu_pkg::*;

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] sec_reg;
    logic [DATA_W-1:0] top_reg,    top_next;
    logic [SP_W-1:0]   sp_reg,     sp_next;
    logic [ST_W-1:0]   status_reg;
    logic [ST_W-1:0]   dec_status;
    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] div_quo;
    logic              div_done;
    logic              ram_we;
    logic              out_valid_reg;
    logic [ST_W-1:0]   out_status_reg;
    logic [DATA_W-1:0] out_top_reg;
    logic [SP_W-1:0]   out_depth_reg;

    assign sp_m1  = sp_reg - SP_W'(1);
    assign sp_m2  = sp_reg - SP_W'(2);
    assign ram_we = cmd.push_commit && (sp_reg != '0);

    // RAM holds the entries below the top; the top lives in top_reg
    smalu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sp_m1[AW-1:0]),
        .wdata (top_reg),
        .raddr (sp_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    smalu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (ram_rdata),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        case (op_reg)
            OP_PUSH:
            begin
                dec_status = (sp_reg >= SP_W'(STACK_DEPTH)) ? ST_OVERFLOW : ST_OK;
            end
            OP_ADD, OP_SUB, OP_MUL:
            begin
                dec_status = (sp_reg < SP_W'(ARITH_ARG_COUNT)) ? ST_UNDERFLOW : ST_OK;
            end
            OP_DIV:
            begin
                if (sp_reg < SP_W'(ARITH_ARG_COUNT))
                begin
                    dec_status = ST_UNDERFLOW;
                end
                else if (top_reg == '0)
                begin
                    dec_status = ST_DIVZERO;
                end
                else
                begin
                    dec_status = ST_OK;
                end
            end
            default:
            begin
                dec_status = ST_ILLEGAL;
            end
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu_res = sec_reg + top_reg;
            OP_SUB:  alu_res = sec_reg - top_reg;
            OP_MUL:  alu_res = sec_reg * top_reg;
            default: alu_res = sec_reg;
        endcase
    end

    always_comb
    begin
        top_next = top_reg;
        sp_next  = sp_reg;
        if (cmd.push_commit)
        begin
            top_next = val_reg;
            sp_next  = sp_reg + SP_W'(1);
        end
        else if (cmd.alu_commit)
        begin
            top_next = alu_res;
            sp_next  = sp_m1;
        end
        else if (cmd.div_commit)
        begin
            top_next = div_quo;
            sp_next  = sp_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg <= sp_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (cmd.load)
        begin
            op_reg  <= in_op;
            val_reg <= in_push_value;
        end
        if (cmd.decode)
        begin
            status_reg <= dec_status;
        end
        if (cmd.sec_load)
        begin
            sec_reg <= ram_rdata;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_top_reg    <= (sp_reg == '0) ? '0 : top_reg;
            out_depth_reg  <= sp_reg;
        end
    end

    assign sts.is_push  = (op_reg == OP_PUSH);
    assign sts.is_div   = (op_reg == OP_DIV);
    assign sts.ok       = (dec_status == ST_OK);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_top_value   = out_top_reg;
    assign out_stack_depth = out_depth_reg;

endmodule

`default_nettype wire

FILE: sv/stack_machine_alu.sv
// Steps per instruction: accept, decode, then for add, sub and mul a second-operand read and
// execute, for div a second-operand read and the 32-step bit-serial divider; push and errors go
// from decode straight to the output stage. One instruction is in flight at a time; a new
// transfer is taken while the previous result still waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the stack; stored values are not cleared.
`default_nettype none

`include "stack_machine_alu_macros.svh"

module stack_machine_alu #(
    parameter int  STACK_DEPTH = smalu_pkg::STACK_DEPTH_DEF,
    localparam int SP_W        = $clog2(STACK_DEPTH + 1),
    localparam int M_TDATA_W   = ((smalu_pkg::ST_W + smalu_pkg::DATA_W + SP_W + 7) / 8) * 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [smalu_pkg::S_TDATA_W-1:0] s_tdata,   // op, push_value
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [M_TDATA_W-1:0]            m_tdata    // status, top_value, stack_depth
);

    import smalu_pkg::*;

    localparam int M_USED_W = ST_W + DATA_W + SP_W;

    smalu_cmd_t        cmd;
    smalu_sts_t        sts;
    logic [ST_W-1:0]   out_status;
    logic [DATA_W-1:0] out_top_value;
    logic [SP_W-1:0]   out_stack_depth;

    smalu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    smalu_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_op           (s_tdata[OP_W-1:0]),
        .in_push_value   (s_tdata[OP_W +: DATA_W]),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_status      (out_status),
        .out_top_value   (out_top_value),
        .out_stack_depth (out_stack_depth)
    );

    assign m_tdata = M_TDATA_W'({out_stack_depth, out_top_value, out_status});

    `SMALU_ASSERT_IMPL(a_no_result_overwrite, cmd.out_load, sts.out_free)
    `SMALU_ASSERT_NEXT(a_one_item_in_flight, s_tvalid && s_tready, !s_tready)
    `SMALU_ASSERT_IMPL(a_underflow_depth, m_tvalid && (out_status == ST_UNDERFLOW),
                       out_stack_depth < SP_W'(ARITH_ARG_COUNT))
    `SMALU_ASSERT_IMPL(a_depth_bound, m_tvalid,
                       (out_stack_depth <= SP_W'(STACK_DEPTH)) && (M_USED_W <= M_TDATA_W))

endmodule

`default_nettype wire
